[sv/idq_pkg.sv]
// Shared widths, operation codes and cell commands for the integer deque.
package idq_pkg;

  localparam int DataW   = 32;
  localparam int OpW     = 3;
  localparam int CountW  = 5;
  localparam int StatusW = 2;
  localparam int DefaultDepth = 16;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // The command that every cell of the chain carries out.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROTATE
  } cell_cmd_t;

endpackage

[sv/int_deque_with_count_sum.sv]
// Top level of the bounded integer deque with running count and sum.
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per word: opcode and
//   push_value. Output channel (out_valid/out_ready) carries result words: value,
//   entry_count, total, status and last.
//   Entries live in a chain of DEPTH cells with the front word in cell 0; push
//   front and pop front shift the whole chain, push back fills the free cell and
//   pop back taps the tail cell. Push and pop: one result word, valid in the cycle
//   after accept. List: one result word per stored entry, one per cycle while the
//   receiver takes them, produced by rotating the chain through cell 0; the input
//   is held off until the final word has been handed over.
//   A new operation is taken while the output register still holds an unread
//   result only if that result is taken in the same cycle.
//   If the receiver stalls, the output register holds its word and listing pauses.
//   Reset empties the deque and clears the sum; cell contents are not cleared.
module int_deque_with_count_sum import idq_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OpW-1:0]            opcode,
  input  logic signed [DataW-1:0]   push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DataW-1:0]   value,
  output logic [CountW-1:0]         entry_count,
  output logic signed [DataW-1:0]   total,
  output logic [StatusW-1:0]        status,
  output logic                      last
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneCount  = CntW'(1);

  logic [CntW-1:0]  count;
  logic [CntW-1:0]  remain;
  logic             listing;
  logic [DataW-1:0] sum;

  logic [DataW-1:0] cell_data [DEPTH];
  logic [DataW-1:0] tail_taps [DEPTH];
  logic [DataW-1:0] tail_or   [DEPTH+1];
  logic [DataW-1:0] head;
  logic [DataW-1:0] tail_value;

  logic      accept;
  logic      slot_free;
  logic      is_empty;
  logic      is_full;
  logic      load_result;
  cell_cmd_t cmd;

  assign head       = cell_data[0];
  assign is_empty   = (count == '0);
  assign is_full    = (count == FullCount);
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = !listing && slot_free;
  assign accept     = in_valid && in_ready;
  assign tail_or[0] = '0;
  assign tail_value = tail_or[DEPTH];
  // a list of a non-empty deque gives no word in its accept cycle
  assign load_result = accept ? !((opcode == OP_LIST) && !is_empty)
                              : (listing && slot_free);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] left_in;
    logic [DataW-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = push_value;
    end else begin : g_mid_left
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = head;
    end else begin : g_mid_right
      assign right_in = cell_data[i+1];
    end

    idq_cell #(
      .Idx       (i),
      .CountBits (CntW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .push_value (push_value),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (head),
      .data       (cell_data[i]),
      .tail_tap   (tail_taps[i])
    );

    assign tail_or[i+1] = tail_or[i] | tail_taps[i];
  end

  always_comb begin
    cmd = CMD_HOLD;
    if (accept) begin
      case (opcode)
        OP_PUSH_FRONT: if (!is_full)  cmd = CMD_PUSH_FRONT;
        OP_PUSH_BACK:  if (!is_full)  cmd = CMD_PUSH_BACK;
        OP_POP_FRONT:  if (!is_empty) cmd = CMD_POP_FRONT;
        default:       cmd = CMD_HOLD;
      endcase
    end else if (listing && slot_free) begin
      cmd = CMD_ROTATE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      listing   <= 1'b0;
      remain    <= '0;
      count     <= '0;
      sum       <= '0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        case (opcode)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (!is_full) begin
              count <= count + OneCount;
              sum   <= sum + push_value;
            end
          end
          OP_POP_FRONT: begin
            if (!is_empty) begin
              count <= count - OneCount;
              sum   <= sum - head;
            end
          end
          OP_POP_BACK: begin
            if (!is_empty) begin
              count <= count - OneCount;
              sum   <= sum - tail_value;
            end
          end
          OP_LIST: begin
            if (!is_empty) begin
              listing <= 1'b1;
              remain  <= count;
            end
          end
          default: begin
          end
        endcase
      end else if (listing && slot_free) begin
        remain    <= remain - OneCount;
        if (remain == OneCount) begin
          listing <= 1'b0;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= '0;
      last  <= 1'b1;
      case (opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (is_full) begin
            status      <= ST_FULL;
            entry_count <= CountW'(count);
            total       <= sum;
          end else begin
            status      <= ST_OK;
            entry_count <= CountW'(count + OneCount);
            total       <= sum + push_value;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status      <= ST_EMPTY;
            entry_count <= CountW'(count);
            total       <= sum;
          end else begin
            status      <= ST_OK;
            value       <= head;
            entry_count <= CountW'(count - OneCount);
            total       <= sum - head;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status      <= ST_EMPTY;
            entry_count <= CountW'(count);
            total       <= sum;
          end else begin
            status      <= ST_OK;
            value       <= tail_value;
            entry_count <= CountW'(count - OneCount);
            total       <= sum - tail_value;
          end
        end
        OP_LIST: begin
          status      <= is_empty ? ST_EMPTY : ST_OK;
          entry_count <= CountW'(count);
          total       <= sum;
        end
        default: begin
          status      <= ST_OK;
          entry_count <= CountW'(count);
          total       <= sum;
        end
      endcase
    end else if (listing && slot_free) begin
      value       <= head;
      status      <= ST_OK;
      entry_count <= CountW'(count);
      total       <= sum;
      last        <= (remain == OneCount);
    end
  end

endmodule

[sv/idq_cell.sv]
// One entry of the deque chain: holds a word and trades it with its neighbours.
module idq_cell import idq_pkg::*; #(
  parameter int Idx    = 0,
  parameter int CountBits = 5
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic [CountBits-1:0] count,
  input  logic [DataW-1:0]     push_value,
  input  logic [DataW-1:0]     left_data,
  input  logic [DataW-1:0]     right_data,
  input  logic [DataW-1:0]     head_data,
  output logic [DataW-1:0]     data,
  output logic [DataW-1:0]     tail_tap
);

  localparam logic [CountBits-1:0] MyPos   = CountBits'(Idx);
  localparam logic [CountBits-1:0] NextPos = CountBits'(Idx + 1);

  logic is_tail;
  logic is_free_slot;

  assign is_tail      = (count == NextPos);
  assign is_free_slot = (count == MyPos);
  assign tail_tap     = is_tail ? data : '0;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_PUSH_FRONT: data <= left_data;
      CMD_PUSH_BACK: begin
        if (is_free_slot) begin
          data <= push_value;
        end
      end
      CMD_POP_FRONT:  data <= right_data;
      // wrap the front word round to the tail so the order comes back after count steps
      CMD_ROTATE:     data <= is_tail ? head_data : right_data;
      default:        data <= data;
    endcase
  end

endmodule
